// ----- rtl/sensor_frame_crc_decoder_core_assert.svh -----
// Assertion macros used by the sensor frame decoder RTL.
`ifndef SENSOR_FRAME_CRC_DECODER_CORE_ASSERT_SVH
`define SENSOR_FRAME_CRC_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SFCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfcd assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define SFCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfcd assertion failed");

`endif

// ----- rtl/sfcd_pkg.sv -----
// Package: constants, types and helper functions of the sensor frame decoder.
`timescale 1ns / 1ps

package sfcd_pkg;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [2:0]  FRAME_FIRST  = 3'd0;
  localparam logic [2:0]  POS_HUM_HI   = 3'd2;
  localparam logic [2:0]  POS_HUM_LO   = 3'd3;
  localparam logic [2:0]  POS_TEMP_HI  = 3'd4;
  localparam logic [2:0]  POS_TEMP_LO  = 3'd5;
  localparam logic [2:0]  POS_CRC_LO   = 3'd6;
  localparam logic [2:0]  FRAME_LAST   = 3'd7;
  localparam logic [2:0]  CRC_LAST_POS = POS_TEMP_LO;

  // x / 10 == (x * 52429) >> 19, exact for x up to 81919
  localparam logic [16:0] RECIP_DIV10  = 17'd52429;
  localparam int          DIV10_SHIFT  = 19;

  typedef struct packed {
    logic signed [12:0] whole;
    logic signed [4:0]  tenth;
  } split_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Signed split into value / 10 and value % 10, truncated toward zero.
  function automatic split_t split10(input logic [15:0] value);
    logic        neg;
    logic [15:0] mag;
    logic [32:0] prod;
    logic [13:0] quo;
    logic [17:0] quo_x10;
    logic [3:0]  rem;
    split_t      res;
    neg     = value[15];
    mag     = neg ? 16'(~value + 16'd1) : value;
    prod    = 33'(mag) * 33'(RECIP_DIV10);
    quo     = prod[32:DIV10_SHIFT];
    quo_x10 = 18'({quo, 3'b000}) + 18'({quo, 1'b0});
    rem     = 4'(mag - quo_x10[15:0]);
    res.whole = neg ? -$signed(quo[12:0]) : $signed(quo[12:0]);
    res.tenth = neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
    return res;
  endfunction

endpackage

// ----- rtl/sensor_frame_crc_decoder_core.sv -----
// Top level: byte-wise sensor frame decoder with CRC-16 check and value split.
`timescale 1ns / 1ps
// Byte 7 passes the input register, then the result register sets result_valid.
// Throughput: one byte per cycle; one input register feeds one result register.
// Only the frame's last byte waits on result_stall, while an older result is held.
// Reset (rst, synchronous, active high): empties both stages, CRC to 0xFFFF,
// byte position and all raw and held values to zero.

`include "sensor_frame_crc_decoder_core_assert.svh"

module sensor_frame_crc_decoder_core (
  input  logic               clk,
  input  logic               rst,
  // byte requests
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  // result requests
  output logic               result_valid,
  input  logic               result_stall,
  output logic               crc_error,
  output logic signed [12:0] humidity_whole,
  output logic signed [4:0]  humidity_tenth,
  output logic signed [12:0] temperature_whole,
  output logic signed [4:0]  temperature_tenth
);

  // Input stage
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_start;

  // Frame state
  logic [15:0] running_crc;
  logic [2:0]  byte_position;
  logic [15:0] humidity_raw;
  logic [15:0] temperature_raw;
  logic [7:0]  received_crc_low;

  // Work on the byte in the input stage
  logic [2:0]  s1_pos;
  logic [15:0] crc_base;
  logic [15:0] running_crc_next;
  logic        s1_in_crc;
  logic        s1_last;
  logic        s1_blocked;
  logic        s1_fire;
  logic        crc_mismatch;
  sfcd_pkg::split_t hum_split;
  sfcd_pkg::split_t temp_split;

  // frame_start forces byte 0; otherwise the position just wraps mod 8
  assign s1_pos    = s1_start ? sfcd_pkg::FRAME_FIRST : byte_position;
  assign s1_last   = (s1_pos == sfcd_pkg::FRAME_LAST);
  assign s1_in_crc = s1_pos inside {[sfcd_pkg::FRAME_FIRST:sfcd_pkg::CRC_LAST_POS]};

  assign crc_base         = (s1_pos == sfcd_pkg::FRAME_FIRST) ? sfcd_pkg::CRC_INIT
                                                              : running_crc;
  assign running_crc_next = sfcd_pkg::crc_byte(crc_base, s1_byte);

  // CRC arrives low byte first; the high byte is the one in the stage now
  assign crc_mismatch = ({s1_byte, received_crc_low} != running_crc);

  // Raw values are complete long before byte 7; split them in parallel with the compare
  assign hum_split  = sfcd_pkg::split10(humidity_raw);
  assign temp_split = sfcd_pkg::split10(temperature_raw);

  // The last byte needs the result register; other bytes always move on
  assign s1_blocked = s1_last && result_valid && result_stall;
  assign s1_fire    = s1_valid && !s1_blocked;
  assign byte_stall = s1_valid && s1_blocked;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      s1_byte  <= rx_byte;
      s1_start <= frame_start;
    end
  end

  // Frame state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc       <= sfcd_pkg::CRC_INIT;
      byte_position     <= sfcd_pkg::FRAME_FIRST;
      humidity_raw      <= '0;
      temperature_raw   <= '0;
      received_crc_low  <= '0;
      result_valid      <= 1'b0;
      crc_error         <= 1'b0;
      humidity_whole    <= '0;
      humidity_tenth    <= '0;
      temperature_whole <= '0;
      temperature_tenth <= '0;
    end else begin
      if (s1_fire) begin
        byte_position <= s1_pos + 3'd1;
        if (s1_in_crc) begin
          running_crc <= running_crc_next;
        end
        case (s1_pos)
          sfcd_pkg::POS_HUM_HI:  humidity_raw[15:8]    <= s1_byte;
          sfcd_pkg::POS_HUM_LO:  humidity_raw[7:0]     <= s1_byte;
          sfcd_pkg::POS_TEMP_HI: temperature_raw[15:8] <= s1_byte;
          sfcd_pkg::POS_TEMP_LO: temperature_raw[7:0]  <= s1_byte;
          sfcd_pkg::POS_CRC_LO:  received_crc_low      <= s1_byte;
          default: begin
          end
        endcase
      end

      if (s1_fire && s1_last) begin
        result_valid <= 1'b1;
        crc_error    <= crc_mismatch;
        // held values double as the output fields; a bad frame leaves them alone
        if (!crc_mismatch) begin
          humidity_whole    <= hum_split.whole;
          humidity_tenth    <= hum_split.tenth;
          temperature_whole <= temp_split.whole;
          temperature_tenth <= temp_split.tenth;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Assertions
  `SFCD_ASSERT_NEXT(a_last_gives_result, s1_fire && s1_last, result_valid)
  `SFCD_ASSERT_NEXT(a_position_advances, s1_fire, byte_position == 3'($past(s1_pos) + 3'd1))
  `SFCD_ASSERT_NEXT(a_blocked_byte_kept, s1_valid && !s1_fire,
                    s1_valid && $stable(s1_byte) && $stable(s1_start))
  `SFCD_ASSERT_NEXT(a_held_only_on_match, !(s1_fire && s1_last && !crc_mismatch),
                    $stable(humidity_whole) && $stable(temperature_whole))
  `SFCD_ASSERT_NOW(a_tenth_range, result_valid,
                   humidity_tenth <= 5'sd9 && humidity_tenth >= -5'sd9 &&
                   temperature_tenth <= 5'sd9 && temperature_tenth >= -5'sd9)

endmodule
